// ===== hw/rtl/mres_pkg.sv =====
// Shared types for the mixed relative error sum unit.
// Holds the controller state encoding and the command/status structs.
// No dependencies.
package mres_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_SUM,
		ST_ROOT,
		ST_MAG,
		ST_DIV_INIT,
		ST_DIV,
		ST_ACC
	} mres_state_t;

	typedef struct packed {
		logic load;       // capture input beat
		logic mag_sel;    // 0: value pair, 1: reference pair
		logic sq_re;      // square real part
		logic sq_im;      // square imaginary part, keep real square
		logic sum;        // add squares, start root
		logic root_step;  // one root digit
		logic store_vmag; // park value magnitude
		logic div_init;   // build divisor and numerator
		logic div_step;   // one quotient bit
		logic acc;        // accumulate quotient, maybe emit result
	} mres_cmd_t;

	typedef struct packed {
		logic last;       // captured item closes the set
		logic out_busy;   // result register still holds an untaken beat
	} mres_status_t;

endpackage

// ===== hw/rtl/mres_coef_if.sv =====
// Coefficient input channel: valid/ready plus one coefficient pair.
// Depends on nothing.
interface mres_coef_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] var_re;
	logic signed [31:0] var_im;
	logic signed [31:0] ref_re;
	logic signed [31:0] ref_im;
	logic               last;

	modport source (output valid, var_re, var_im, ref_re, ref_im, last, input ready);
	modport sink   (input valid, var_re, var_im, ref_re, ref_im, last, output ready);
endinterface

// ===== hw/rtl/mres_result_if.sv =====
// Result output channel: valid/ready plus the summed norm and flag.
// Depends on nothing.
interface mres_result_if;
	logic        valid;
	logic        ready;
	logic [47:0] norm_sum;
	logic        saturated;

	modport source (output valid, norm_sum, saturated, input ready);
	modport sink   (input valid, norm_sum, saturated, output ready);
endinterface

// ===== hw/rtl/mres_ctrl.sv =====
// Sequencing FSM for the mixed relative error sum unit.
// Depends on mres_pkg.
module mres_ctrl import mres_pkg::*; #(
	parameter int DIV_STEPS = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  mres_status_t status,
	output mres_cmd_t    cmd
);

	localparam int ROOT_STEPS = 32;
	localparam int MAXS = (DIV_STEPS > ROOT_STEPS) ? DIV_STEPS : ROOT_STEPS;
	localparam int CW = $clog2(MAXS);

	mres_state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		sel_d    = sel_q;
		cmd      = '0;
		cmd.mag_sel = sel_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					sel_d    = 1'b0;
					state_d  = ST_SQ_RE;
				end
			end
			ST_SQ_RE: begin
				cmd.sq_re = 1'b1;
				state_d   = ST_SQ_IM;
			end
			ST_SQ_IM: begin
				cmd.sq_im = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				cnt_d   = '0;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CW'(ROOT_STEPS - 1)) state_d = ST_MAG;
			end
			ST_MAG: begin
				if (!sel_q) begin
					cmd.store_vmag = 1'b1;
					sel_d   = 1'b1;
					state_d = ST_SQ_RE;
				end else begin
					state_d = ST_DIV_INIT;
				end
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_STEPS - 1)) state_d = ST_ACC;
			end
			ST_ACC: begin
				if (!(status.last && status.out_busy)) begin
					cmd.acc = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/mres_dp.sv =====
// Datapath: shared squarer, bit-serial root, restoring divider, accumulator.
// Depends on mres_pkg; driven by mres_ctrl commands.
module mres_dp import mres_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int ACC_WIDTH = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mres_cmd_t          cmd,
	output mres_status_t       status,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic signed [31:0] in_var_re,
	input  logic signed [31:0] in_var_im,
	input  logic signed [31:0] in_ref_re,
	input  logic signed [31:0] in_ref_im,
	input  logic               in_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [47:0]        out_norm_sum,
	output logic               out_saturated
);

	localparam int NUMW = 32 + FRAC_BITS;
	localparam int CW   = (NUMW > ACC_WIDTH) ? NUMW : ACC_WIDTH;
	localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

	logic [31:0] eta_q;
	logic signed [31:0] vre_q, vim_q, rre_q, rim_q;
	logic last_q;
	logic [63:0] prod_q, sumsq_q, x_q;
	logic [33:0] rrem_q;
	logic [31:0] root_q, vmag_q;
	logic [32:0] den_q, drem_q;
	logic [NUMW-1:0] num_q, quo_q;
	logic [ACC_WIDTH-1:0] acc_q;
	logic sat_q;
	logic [47:0] out_sum_q;
	logic out_sat_q, out_vld_q;

	// squarer operand
	logic signed [31:0] op_s;
	logic [31:0] op_abs;
	logic [63:0] sq;
	always_comb begin
		if (cmd.mag_sel) op_s = cmd.sq_im ? rim_q : rre_q;
		else             op_s = cmd.sq_im ? vim_q : vre_q;
		op_abs = op_s[31] ? (~op_s + 32'd1) : op_s;
		sq     = 64'(op_abs) * 64'(op_abs);
	end

	// one root digit
	logic [35:0] rrem_sh, rtrial;
	logic rfit;
	assign rrem_sh = {rrem_q, x_q[63:62]};
	assign rtrial  = {2'b00, root_q, 2'b01};
	assign rfit    = rrem_sh >= rtrial;

	// one quotient bit
	logic [33:0] drem_sh;
	logic dfit;
	logic [33:0] dsub;
	assign drem_sh = {drem_q, num_q[NUMW-1]};
	assign dfit    = drem_sh >= {1'b0, den_q};
	assign dsub    = drem_sh - {1'b0, den_q};

	// quotient clamp and accumulate
	logic [CW-1:0] quo_ext;
	logic quo_big, den_zero;
	logic [ACC_WIDTH-1:0] qv, acc_nx;
	logic [ACC_WIDTH:0] acc_sum;
	logic sat_nx;
	logic [ACC_WIDTH+47:0] acc_wide;
	always_comb begin
		quo_ext  = CW'(quo_q);
		den_zero = (den_q == '0);
		quo_big  = quo_ext > CW'(ACC_MAX);
		qv       = (den_zero || quo_big) ? ACC_MAX : quo_ext[ACC_WIDTH-1:0];
		acc_sum  = {1'b0, acc_q} + {1'b0, qv};
		acc_nx   = acc_sum[ACC_WIDTH] ? ACC_MAX : acc_sum[ACC_WIDTH-1:0];
		sat_nx   = sat_q | den_zero | quo_big | acc_sum[ACC_WIDTH];
		acc_wide = {48'd0, acc_nx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_q     <= 32'd1;
			acc_q     <= '0;
			sat_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) eta_q <= cfg_wdata;
			// a new result may load in the cycle the old one is taken
			if (cmd.acc && last_q) out_vld_q <= 1'b1;
			else if (out_vld_q && out_ready) out_vld_q <= 1'b0;
			if (cmd.acc) begin
				if (last_q) begin
					acc_q <= '0;
					sat_q <= 1'b0;
				end else begin
					acc_q <= acc_nx;
					sat_q <= sat_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vre_q  <= in_var_re;
			vim_q  <= in_var_im;
			rre_q  <= in_ref_re;
			rim_q  <= in_ref_im;
			last_q <= in_last;
		end
		if (cmd.sq_re) prod_q <= sq;
		if (cmd.sq_im) begin
			sumsq_q <= prod_q;
			prod_q  <= sq;
		end
		if (cmd.sum) begin
			x_q    <= sumsq_q + prod_q;
			rrem_q <= '0;
			root_q <= '0;
		end
		if (cmd.root_step) begin
			x_q <= {x_q[61:0], 2'b00};
			if (rfit) begin
				rrem_q <= 34'(rrem_sh - rtrial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rrem_q <= rrem_sh[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.store_vmag) vmag_q <= root_q;
		if (cmd.div_init) begin
			den_q  <= {1'b0, root_q} + {1'b0, eta_q};
			num_q  <= {vmag_q, {FRAC_BITS{1'b0}}};
			drem_q <= '0;
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			num_q  <= {num_q[NUMW-2:0], 1'b0};
			drem_q <= dfit ? dsub[32:0] : drem_sh[32:0];
			quo_q  <= {quo_q[NUMW-2:0], dfit};
		end
		if (cmd.acc && last_q) begin
			out_sum_q <= acc_wide[47:0];
			out_sat_q <= sat_nx;
		end
	end

	assign status.last     = last_q;
	assign status.out_busy = out_vld_q && !out_ready;
	assign out_valid       = out_vld_q;
	assign out_norm_sum    = out_sum_q;
	assign out_saturated   = out_sat_q;

`ifndef SYNTHESIS
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc && last_q |=> out_vld_q)
		else $error("result not raised after closing item");
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc && !last_q && sat_q |=> sat_q)
		else $error("saturation flag lost within a set");
	a_div_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |=> quo_q == '0)
		else $error("quotient not cleared at divide start");
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc && last_q |-> !(out_vld_q && !out_ready))
		else $error("pending result overwritten");
`endif

endmodule

// ===== hw/rtl/mixed_relative_error_sum_unit.sv =====
// Per item: accept; square real and imaginary parts, sum, root steps for the value pair,
// again for the reference pair; divide init, divide steps, accumulate. One item at a time.
// The rate is set by the bit-serial square root (run twice) and the restoring divider.
// Result beat is registered, so the next item is taken while a result waits.
// arst_n clears the sequencer, the sum, the flag and the result valid; eta resets to 1.
module mixed_relative_error_sum_unit import mres_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int ACC_WIDTH = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata,
	mres_coef_if.sink     coef,
	mres_result_if.source result
);

	mres_cmd_t    cmd;
	mres_status_t status;

	// Sequencer: squares, roots and divide steps, one shared unit each.
	mres_ctrl #(
		.DIV_STEPS(32 + FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (coef.valid),
		.in_ready (coef.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and the sum / flag state, plus the result register.
	mres_dp #(
		.FRAC_BITS(FRAC_BITS),
		.ACC_WIDTH(ACC_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_var_re     (coef.var_re),
		.in_var_im     (coef.var_im),
		.in_ref_re     (coef.ref_re),
		.in_ref_im     (coef.ref_im),
		.in_last       (coef.last),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.out_norm_sum  (result.norm_sum),
		.out_saturated (result.saturated)
	);

endmodule

// ===== test/tb_mixed_relative_error_sum_unit.sv =====
// Testbench for mixed_relative_error_sum_unit: directed and random coefficient beats,
// scoreboard predicts norm_sum/saturated per set. Depends on the unit and the two
// channel interfaces in hw/rtl.
module tb_mixed_relative_error_sum_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = 16;
	localparam int ACC_WIDTH = 48;
	localparam logic [63:0] ACC_MAX = (64'd1 << ACC_WIDTH) - 1;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 160;

	// Scoreboard: models the summing datapath and holds pending set results.
	class norm_scoreboard;
		logic [31:0] eta_q;
		logic [63:0] err_sum;
		logic        sat_seen;
		logic [47:0] exp_sum_q[$];
		logic        exp_sat_q[$];
		int          mismatches;
		int          results_seen;

		function void reset_state();
			eta_q = 32'd1;
			err_sum = '0;
			sat_seen = 1'b0;
			exp_sum_q.delete();
			exp_sat_q.delete();
		endfunction

		function logic [63:0] root_floor(logic [63:0] x);
			logic [63:0] r;
			logic [63:0] b;
			r = '0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function logic [63:0] magnitude(logic signed [31:0] re, logic signed [31:0] im);
			logic [63:0] a;
			logic [63:0] b;
			a = re[31] ? 64'h1_0000_0000 - {32'd0, re} : {32'd0, re};
			b = im[31] ? 64'h1_0000_0000 - {32'd0, im} : {32'd0, im};
			return root_floor(a * a + b * b);
		endfunction

		// Called for each accepted coefficient beat.
		function void note_coef(logic signed [31:0] vr, logic signed [31:0] vi,
				logic signed [31:0] rr, logic signed [31:0] ri, logic lst);
			logic [63:0] vmag;
			logic [63:0] den;
			logic [63:0] q;
			vmag = magnitude(vr, vi);
			den = magnitude(rr, ri) + {32'd0, eta_q};
			if (den == 0) begin
				q = ACC_MAX;
				sat_seen = 1'b1;
			end else begin
				q = (vmag << FRAC_BITS) / den;
				if (q > ACC_MAX) begin
					q = ACC_MAX;
					sat_seen = 1'b1;
				end
			end
			if (q > ACC_MAX - err_sum) begin
				err_sum = ACC_MAX;
				sat_seen = 1'b1;
			end else begin
				err_sum = err_sum + q;
			end
			if (lst) begin
				exp_sum_q.push_back(err_sum[47:0]);
				exp_sat_q.push_back(sat_seen);
				err_sum = '0;
				sat_seen = 1'b0;
			end
		endfunction

		// Called for each accepted result beat.
		function void check_result(logic [47:0] got_sum, logic got_sat);
			logic [47:0] es;
			logic        ef;
			results_seen++;
			if (exp_sum_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: sum=%h sat=%b", got_sum, got_sat);
				return;
			end
			es = exp_sum_q.pop_front();
			ef = exp_sat_q.pop_front();
			if (got_sum !== es || got_sat !== ef) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: sum exp=%h got=%h, sat exp=%b got=%b",
						es, got_sum, ef, got_sat);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	mres_coef_if   coef ();
	mres_result_if result ();

	mixed_relative_error_sum_unit #(
		.FRAC_BITS(FRAC_BITS),
		.ACC_WIDTH(ACC_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.coef     (coef.sink),
		.result   (result.source)
	);

	norm_scoreboard sb;
	bit   idle_enabled;   // random gaps on both sides, off in the final stretch
	int   idle_count;     // cycles since any beat or config write
	int   beats_sent;
	int   sets_closed;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Result sink: bursty backpressure, checks each beat taken.
	initial begin
		int stall;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (idle_enabled && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 13);
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			if (result.valid && result.ready)
				sb.check_result(result.norm_sum, result.saturated);
		end
	end

	// Watchdog: counts cycles with no beat moving.
	always @(posedge clk) begin
		if ((coef.valid && coef.ready) || (result.valid && result.ready) || cfg_we)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("watchdog expired, %0d results pending", sb.exp_sum_q.size());
			$display("tb_mixed_relative_error_sum_unit: errors");
			$finish;
		end
	end

	// Drives one coefficient beat and waits until it is taken. Valid stays up
	// afterwards unless a gap follows; the block is busy long after a beat.
	task automatic send_coef(logic [31:0] vr, logic [31:0] vi, logic [31:0] rr,
			logic [31:0] ri, logic lst);
		int gap;
		if (idle_enabled && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			coef.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coef.valid  <= 1'b1;
		coef.var_re <= vr;
		coef.var_im <= vi;
		coef.ref_re <= rr;
		coef.ref_im <= ri;
		coef.last   <= lst;
		do @(posedge clk); while (!coef.ready);
		sb.note_coef(vr, vi, rr, ri, lst);
		beats_sent++;
		if (lst) sets_closed++;
	endtask

	// Drops valid, waits out all pending results plus one item time, then writes eta.
	task automatic write_eta(logic [31:0] value);
		coef.valid <= 1'b0;
		while (sb.exp_sum_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.eta_q = value;
	endtask

	function automatic logic [31:0] rand_part();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'd0;
			3: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int n);
		logic [31:0] rr;
		logic [31:0] ri;
		for (int i = 0; i < n; i++) begin
			// small references push quotients toward saturation
			if ($urandom_range(0, 3) == 0) begin
				rr = $urandom_range(0, 16) - 8;
				ri = $urandom_range(0, 16) - 8;
			end else begin
				rr = rand_part();
				ri = rand_part();
			end
			send_coef(rand_part(), rand_part(), rr, ri, $urandom_range(0, 3) == 0);
		end
		// close the set so no partial sum crosses a register write
		send_coef($urandom, $urandom, $urandom, $urandom, 1'b1);
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		idle_enabled = 1'b1;
		idle_count   = 0;
		beats_sent   = 0;
		sets_closed  = 0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		coef.valid   = 1'b0;
		coef.var_re  = '0;
		coef.var_im  = '0;
		coef.ref_re  = '0;
		coef.ref_im  = '0;
		coef.last    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset eta of one: zero value, extreme parts, single-beat and two-beat sets.
		send_coef(32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
		send_coef(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 1'b1);
		send_coef(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_coef(32'hffff_ffff, 32'h0001_0000, 32'h8000_0000, 32'hffff_ffff, 1'b1);
		// sum overflow: repeated huge quotients in one set
		for (int i = 0; i < 5; i++)
			send_coef(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, i == 4);
		send_coef(32'h0001_0000, 32'd0, 32'h0001_0000, 32'd0, 1'b1);

		// Zero divisor, with and without a zero value.
		write_eta(32'd0);
		send_coef(32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
		send_coef(32'h0003_0000, 32'h0004_0000, 32'd0, 32'd0, 1'b0);
		send_coef(32'h0003_0000, 32'h0004_0000, 32'h0003_0000, 32'h0004_0000, 1'b1);
		send_coef(32'h0000_0001, 32'd0, 32'h0000_0001, 32'd0, 1'b1);

		write_eta(32'hffff_ffff);
		send_coef(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_coef(32'h7fff_ffff, 32'd0, 32'd0, 32'd0, 1'b1);

		write_eta(32'h0001_0000);
		random_phase(150);
		write_eta(32'd0);
		random_phase(100);
		write_eta(32'hffff_ffff);
		random_phase(80);
		write_eta($urandom);
		random_phase(120);
		write_eta(32'd1);
		idle_enabled = 1'b0;
		random_phase(150);

		coef.valid <= 1'b0;
		while (sb.exp_sum_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d coefficient beats in %0d sets, %0d results checked",
			beats_sent, sets_closed, sb.results_seen);
		$display("eta swept over zero, one, 1.0, max and random; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.exp_sum_q.size() == 0)
			$display("tb_mixed_relative_error_sum_unit: clean");
		else
			$display("tb_mixed_relative_error_sum_unit: errors");
		$finish;
	end
endmodule
